// ----- hw/rtl/dns_question_parser_macros.svh -----
// Assertion macros used by the checker of the DNS question parser.
`ifndef DNS_QUESTION_PARSER_MACROS_SVH
`define DNS_QUESTION_PARSER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define DNSQP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dns question parser check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define DNSQP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dns question parser check failed");

`endif

// ----- hw/rtl/dnsqp_pkg.sv -----
// Package with constants, codes and types of the DNS question parser.
`timescale 1ns / 1ps
package dnsqp_pkg;

  localparam int unsigned NameCapacityDef = 64;
  localparam int unsigned MaxPacketDef    = 512;
  localparam int unsigned HdrLen          = 12;
  localparam int unsigned OpcodeByte      = 2;
  localparam int unsigned TailBytes       = 4;
  localparam int unsigned QueueDepth      = 4;
  localparam logic [7:0]  OpcodeMask      = 8'h78;
  localparam logic [7:0]  LabelTypeMask   = 8'hC0;
  localparam logic [7:0]  DotChar         = 8'h2E;
  localparam logic [7:0]  UpperA          = 8'h41;
  localparam logic [7:0]  UpperZ          = 8'h5A;
  localparam logic [7:0]  CaseBit         = 8'h20;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_LEN,
    PH_LABEL,
    PH_TAIL,
    PH_DONE,
    PH_FAIL
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_SHORT,
    ST_LABEL,
    ST_OPCODE
  } status_e;

  typedef enum logic {
    KIND_CHAR,
    KIND_VERDICT
  } kind_e;

  typedef struct packed {
    logic push0;
    logic push1;
  } push_t;

endpackage

// ----- hw/rtl/dnsqp_if.sv -----
// Handshake interfaces for the byte input and the result output channels.
`timescale 1ns / 1ps
interface dnsqp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface dnsqp_out_if #(
  parameter int unsigned NameW = 6,
  parameter int unsigned OffW  = 10
);
  logic             valid;
  logic             ready;
  logic             kind;
  logic [7:0]       domain_char;
  logic [1:0]       status;
  logic [15:0]      query_type;
  logic [15:0]      query_class;
  logic [OffW-1:0]  question_end;
  logic [NameW-1:0] name_length;
  logic             end_of_run;

  modport source (
    output valid, output kind, output domain_char, output status, output query_type,
    output query_class, output question_end, output name_length, output end_of_run,
    input ready
  );
  modport sink (
    input valid, input kind, input domain_char, input status, input query_type,
    input query_class, input question_end, input name_length, input end_of_run,
    output ready
  );
endinterface

// ----- hw/rtl/dnsqp_parse.sv -----
// Input register and per-byte parse state machine of the DNS question parser.
`timescale 1ns / 1ps
module dnsqp_parse #(
  parameter int unsigned NAME_CAPACITY = dnsqp_pkg::NameCapacityDef,
  parameter int unsigned MAX_PACKET    = dnsqp_pkg::MaxPacketDef,
  parameter int unsigned ResW          = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  dnsqp_in_if.sink            in_i,
  input  logic                room_i,
  output dnsqp_pkg::push_t    push_o,
  output logic [ResW-1:0]     data0_o,
  output logic [ResW-1:0]     data1_o
);
  import dnsqp_pkg::*;

  localparam int unsigned NameW = $clog2(NAME_CAPACITY);
  localparam int unsigned OffW  = $clog2(MAX_PACKET + 1);
  localparam logic [NameW-1:0] NameLimit = NameW'(NAME_CAPACITY - 1);
  localparam logic [OffW-1:0]  OffMax    = OffW'(MAX_PACKET);
  localparam logic [OffW-1:0]  OffOpcode = OffW'(OpcodeByte);
  localparam logic [OffW-1:0]  OffHdrEnd = OffW'(HdrLen - 1);
  localparam logic [OffW-1:0]  OffHdrLen = OffW'(HdrLen);

  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic       take;

  logic [OffW-1:0]  off_q, off_d;
  phase_e           phase_q, phase_d;
  logic [5:0]       left_q, left_d;
  logic [NameW-1:0] cnt_q, cnt_d;
  logic [31:0]      word_q, word_d;
  status_e          err_q, err_d;
  logic [OffW-1:0]  end_q, end_d;

  logic       char_v;
  logic [7:0] char_c;
  logic [7:0] low_c;
  status_e    verdict_st;
  logic [ResW-1:0] char_res;
  logic [ResW-1:0] verdict_res;

  assign take       = in_valid_q && room_i;
  assign in_i.ready = !in_valid_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      byte_q <= in_i.data_byte;
      last_q <= in_i.last_byte;
    end
  end

  always_comb begin
    if (byte_q >= UpperA && byte_q <= UpperZ) begin
      low_c = byte_q | CaseBit;
    end else begin
      low_c = byte_q;
    end
  end

  always_comb begin
    off_d   = off_q;
    phase_d = phase_q;
    left_d  = left_q;
    cnt_d   = cnt_q;
    word_d  = word_q;
    err_d   = err_q;
    end_d   = end_q;
    char_v  = 1'b0;
    char_c  = 8'h00;
    if (off_q < OffMax) begin
      case (phase_q)
        PH_HEADER: begin
          if (off_q == OffOpcode && (byte_q & OpcodeMask) != 8'h00) begin
            err_d = ST_OPCODE;
          end
          if (off_q == OffHdrEnd) begin
            phase_d = (err_d != ST_OK) ? PH_FAIL : PH_LEN;
          end
        end
        PH_LEN: begin
          if (byte_q == 8'h00) begin
            phase_d = PH_TAIL;
            left_d  = 6'(TailBytes);
          end else if ((byte_q & LabelTypeMask) != 8'h00) begin
            err_d   = ST_LABEL;
            phase_d = PH_FAIL;
          end else begin
            if (cnt_q != '0 && cnt_q < NameLimit) begin
              char_v = 1'b1;
              char_c = DotChar;
              cnt_d  = cnt_q + 1'b1;
            end
            left_d  = byte_q[5:0];
            phase_d = PH_LABEL;
          end
        end
        PH_LABEL: begin
          if (cnt_q < NameLimit) begin
            char_v = 1'b1;
            char_c = low_c;
            cnt_d  = cnt_q + 1'b1;
          end
          left_d = left_q - 1'b1;
          if (left_d == '0) begin
            phase_d = PH_LEN;
          end
        end
        PH_TAIL: begin
          word_d = {word_q[23:0], byte_q};
          left_d = left_q - 1'b1;
          if (left_d == '0) begin
            phase_d = PH_DONE;
            end_d   = off_q + 1'b1;
          end
        end
        default: begin
        end
      endcase
      off_d = off_q + 1'b1;
    end

    if (off_d < OffHdrLen) begin
      verdict_st = ST_SHORT;
    end else if (err_d != ST_OK) begin
      verdict_st = err_d;
    end else if (phase_d != PH_DONE) begin
      verdict_st = ST_SHORT;
    end else begin
      verdict_st = ST_OK;
    end

    char_res = {KIND_CHAR, char_c, ST_OK, 16'h0000, 16'h0000, {OffW{1'b0}},
                {NameW{1'b0}}, 1'b0};
    if (verdict_st == ST_OK) begin
      verdict_res = {KIND_VERDICT, 8'h00, ST_OK, word_d[31:16], word_d[15:0], end_d,
                     cnt_d, 1'b1};
    end else begin
      verdict_res = {KIND_VERDICT, 8'h00, verdict_st, 16'h0000, 16'h0000, {OffW{1'b0}},
                     cnt_d, 1'b1};
    end

    if (last_q) begin
      off_d   = '0;
      phase_d = PH_HEADER;
      left_d  = '0;
      cnt_d   = '0;
      word_d  = '0;
      err_d   = ST_OK;
      end_d   = '0;
    end
  end

  assign push_o.push0 = take && (char_v || last_q);
  assign push_o.push1 = take && char_v && last_q;
  assign data0_o      = char_v ? char_res : verdict_res;
  assign data1_o      = verdict_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q   <= '0;
      phase_q <= PH_HEADER;
      left_q  <= '0;
      cnt_q   <= '0;
      word_q  <= '0;
      err_q   <= ST_OK;
      end_q   <= '0;
    end else if (take) begin
      off_q   <= off_d;
      phase_q <= phase_d;
      left_q  <= left_d;
      cnt_q   <= cnt_d;
      word_q  <= word_d;
      err_q   <= err_d;
      end_q   <= end_d;
    end
  end

endmodule

// ----- hw/rtl/dnsqp_queue.sv -----
// Small result queue that takes up to two items a cycle and gives one while ready_i is high.
`timescale 1ns / 1ps
module dnsqp_queue #(
  parameter int unsigned ResW  = 8,
  parameter int unsigned Depth = dnsqp_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dnsqp_pkg::push_t push_i,
  input  logic [ResW-1:0]  data0_i,
  input  logic [ResW-1:0]  data1_i,
  output logic             room_o,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [ResW-1:0]  data_o
);
  import dnsqp_pkg::*;

  localparam int unsigned IdxW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [ResW-1:0] store_q [Depth];
  logic [IdxW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0] wr_next;
  logic            pop;

  assign valid_o = cnt_q != '0;
  assign pop     = valid_o && ready_i;
  assign room_o  = cnt_q <= CntW'(Depth - 2);
  assign data_o  = store_q[rd_q];
  assign wr_next = wr_q + 1'b1;

  always_comb begin
    wr_d  = wr_q + IdxW'(push_i.push0) + IdxW'(push_i.push1);
    rd_d  = rd_q + IdxW'(pop);
    cnt_d = cnt_q + CntW'(push_i.push0) + CntW'(push_i.push1) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push0) begin
      store_q[wr_q] <= data0_i;
    end
    if (push_i.push1) begin
      store_q[wr_next] <= data1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- hw/rtl/dns_question_parser.sv -----
// Top level of the DNS question parser.
//
// The in_i channel takes one packet byte per item, with last_byte set on the
// final byte of the packet. The out_o channel gives one item per emitted name
// character (kind 0) and one verdict item (kind 1, end_of_run set) after the
// final byte. Header bytes are skipped, the opcode is checked, QNAME labels are
// lowercased and joined with dots, and QTYPE and QCLASS are returned on success.
// On a nonzero status the consumer discards the characters of that packet.
// An accepted byte passes the input register, then the result queue, before its
// first result reaches out_o. Throughput is one byte per cycle while the queue
// has room; a byte that yields both a character and the verdict puts two items
// in the queue, which drains at one item per cycle while out_o.ready is high.
// The result queue holds four items; a stalled receiver fills it and in_i.ready
// then falls until room for two items is back, with no item lost.
// Reset clears the parse state and empties the queue; the parser also returns
// to its reset state by itself after each verdict.
`timescale 1ns / 1ps
module dns_question_parser #(
  parameter int unsigned NAME_CAPACITY = dnsqp_pkg::NameCapacityDef,
  parameter int unsigned MAX_PACKET    = dnsqp_pkg::MaxPacketDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dnsqp_in_if.sink   in_i,
  dnsqp_out_if.source out_o
);
  import dnsqp_pkg::*;

  localparam int unsigned NameW = $clog2(NAME_CAPACITY);
  localparam int unsigned OffW  = $clog2(MAX_PACKET + 1);
  localparam int unsigned ResW  = 1 + 8 + 2 + 16 + 16 + OffW + NameW + 1;

  push_t           push;
  logic            room;
  logic [ResW-1:0] data0;
  logic [ResW-1:0] data1;
  logic [ResW-1:0] head;

  dnsqp_parse #(
    .NAME_CAPACITY(NAME_CAPACITY),
    .MAX_PACKET   (MAX_PACKET),
    .ResW         (ResW)
  ) u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .room_i (room),
    .push_o (push),
    .data0_o(data0),
    .data1_o(data1)
  );

  dnsqp_queue #(
    .ResW (ResW),
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data0_i(data0),
    .data1_i(data1),
    .room_o (room),
    .valid_o(out_o.valid),
    .ready_i(out_o.ready),
    .data_o (head)
  );

  assign {out_o.kind, out_o.domain_char, out_o.status, out_o.query_type, out_o.query_class,
          out_o.question_end, out_o.name_length, out_o.end_of_run} = head;

endmodule

// ----- hw/rtl/dnsqp_checker.sv -----
// Port-level checker of the DNS question parser and its bind to the top level.
`timescale 1ns / 1ps
`include "dns_question_parser_macros.svh"
module dnsqp_checker #(
  parameter int unsigned NAME_CAPACITY = dnsqp_pkg::NameCapacityDef,
  parameter int unsigned MAX_PACKET    = dnsqp_pkg::MaxPacketDef
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic                               kind_i,
  input logic [7:0]                         domain_char_i,
  input logic [1:0]                         status_i,
  input logic [15:0]                        query_type_i,
  input logic [15:0]                        query_class_i,
  input logic [$clog2(MAX_PACKET + 1)-1:0]  question_end_i,
  input logic [$clog2(NAME_CAPACITY)-1:0]   name_length_i,
  input logic                               end_of_run_i
);
  import dnsqp_pkg::*;

  `DNSQP_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, out_valid_i && !out_ready_i,
    out_valid_i && $stable(kind_i) && $stable(domain_char_i) && $stable(status_i)
    && $stable(name_length_i) && $stable(end_of_run_i))
  `DNSQP_ASSERT_NOW(a_char_clean, clk_i, rst_ni, out_valid_i && kind_i == KIND_CHAR,
    !end_of_run_i && status_i == ST_OK && name_length_i == '0 && question_end_i == '0)
  `DNSQP_ASSERT_NOW(a_verdict_ends, clk_i, rst_ni, out_valid_i && kind_i == KIND_VERDICT,
    end_of_run_i && domain_char_i == 8'h00)
  `DNSQP_ASSERT_NOW(a_error_zero, clk_i, rst_ni,
    out_valid_i && kind_i == KIND_VERDICT && status_i != ST_OK,
    query_type_i == 16'h0000 && query_class_i == 16'h0000 && question_end_i == '0)

endmodule

bind dns_question_parser dnsqp_checker #(
  .NAME_CAPACITY(NAME_CAPACITY),
  .MAX_PACKET   (MAX_PACKET)
) u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .kind_i        (out_o.kind),
  .domain_char_i (out_o.domain_char),
  .status_i      (out_o.status),
  .query_type_i  (out_o.query_type),
  .query_class_i (out_o.query_class),
  .question_end_i(out_o.question_end),
  .name_length_i (out_o.name_length),
  .end_of_run_i  (out_o.end_of_run)
);
